>>> hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps
package cdq_pkg;

  localparam int CdqCapacity  = 256;
  localparam int CdqDataWidth = 32;
  // cells between two scan pipeline registers
  localparam int CdqGroup     = 8;

  typedef enum logic [2:0] {
    CMD_FRONT_IN  = 3'd0,
    CMD_BACK_IN   = 3'd1,
    CMD_FRONT_OUT = 3'd2,
    CMD_BACK_OUT  = 3'd3,
    CMD_READ_AT   = 3'd4,
    CMD_RESIZE    = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_RANGE = 3'd3,
    ST_BIG   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR,
    CELL_FILL
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/cdq_cell.sv
`timescale 1ns / 1ps
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int IDX      = 0,
  parameter int DW       = CdqDataWidth,
  parameter int CW       = 9,
  parameter int IW       = 8,
  parameter bit REG_SCAN = 1'b0
) (
  input  logic          clk,
  input  cell_op_t      op,
  input  logic [CW-1:0] lo,
  input  logic [CW-1:0] hi,
  input  logic [DW-1:0] wdata,
  input  logic [DW-1:0] left_in,
  input  logic [DW-1:0] right_in,
  output logic [DW-1:0] data_o,
  input  logic [IW-1:0] sel_a,
  input  logic [IW-1:0] sel_b,
  input  logic [DW-1:0] scan_a_in,
  input  logic [DW-1:0] scan_b_in,
  output logic [DW-1:0] scan_a_o,
  output logic [DW-1:0] scan_b_o
);

  logic [DW-1:0] data_r, data_nxt;
  logic [DW-1:0] scan_a_c, scan_b_c;
  logic          in_fill;

  assign in_fill = (lo <= CW'(IDX)) && (CW'(IDX) < hi);

  always_comb begin
    data_nxt = data_r;
    case (op)
      CELL_SHL:  data_nxt = right_in;
      CELL_SHR:  data_nxt = left_in;
      CELL_FILL: if (in_fill) data_nxt = wdata;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o   = data_r;
  assign scan_a_c = (sel_a == IW'(IDX)) ? data_r : scan_a_in;
  assign scan_b_c = (sel_b == IW'(IDX)) ? data_r : scan_b_in;

  generate
    if (REG_SCAN) begin : g_reg
      logic [DW-1:0] scan_a_r, scan_b_r;
      always_ff @(posedge clk) begin
        scan_a_r <= scan_a_c;
        scan_b_r <= scan_b_c;
      end
      assign scan_a_o = scan_a_r;
      assign scan_b_o = scan_b_r;
    end else begin : g_comb
      assign scan_a_o = scan_a_c;
      assign scan_b_o = scan_b_c;
    end
  endgenerate

endmodule

>>> hw/rtl/circular_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Double-ended queue of up to CAPACITY words, held as a row of cells where
// cell i always holds the entry at logical index i from the front. Push and
// pop at the front shift the whole row by one place; push and pop at the back
// and resize move only the count and fill any new back cells in parallel.
// The read and back entries are found by two select chains through the cells,
// registered every eight cells; the result is posted once both have drained,
// and only then is the next item accepted. One item is in work at a time; a new
// item is taken while the previous result still waits in the output register,
// and the result of that new item is held until the output register is free.
// Faults (push when full, pop when empty, read past the end, resize over
// capacity) leave the queue unchanged and are reported in status.
module circular_double_ended_queue_unit
  import cdq_pkg::*;
#(
  parameter int CAPACITY   = CdqCapacity,
  parameter int DATA_WIDTH = CdqDataWidth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_item_value,
  input  logic [7:0]  in_position,
  input  logic [8:0]  in_target_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_word,
  output logic [31:0] out_front_word,
  output logic [31:0] out_back_word,
  output logic [8:0]  out_occupancy,
  output logic        out_is_empty,
  output logic [2:0]  out_status
);

  localparam int DW   = DATA_WIDTH;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int NSTG = (CAPACITY + CdqGroup - 1) / CdqGroup;
  localparam int SCW  = $clog2(NSTG + 1);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SCW-1:0] scnt_r, scnt_nxt;
  logic [IW-1:0]  sel_a_r, sel_a_nxt, sel_b_r, sel_b_nxt;
  status_t        stat_r, stat_nxt;
  logic           rd_ok_r, rd_ok_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    o_read_r, o_front_r, o_back_r;
  logic [8:0]     o_occ_r;
  logic           o_empty_r;
  logic [2:0]     o_stat_r;
  logic           load_out;

  cell_op_t       op;
  logic [CW-1:0]  lo, hi;
  logic [DW-1:0]  wdata;
  logic           accept;
  cmd_t           cmd;
  logic           full, empty;

  logic [DW-1:0]  data_w   [CAPACITY];
  logic [DW-1:0]  scan_a_w [CAPACITY];
  logic [DW-1:0]  scan_b_w [CAPACITY];

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cmd    = cmd_t'(in_cmd);
  assign wdata  = DW'(in_item_value);
  assign full   = (32'(count_r) >= 32'(CAPACITY));
  assign empty  = (count_r == '0);

  // command decode: queue update happens at the accept edge
  always_comb begin
    op        = CELL_HOLD;
    lo        = count_r;
    hi        = count_r;
    count_nxt = count_r;
    stat_nxt  = stat_r;
    rd_ok_nxt = rd_ok_r;
    sel_a_nxt = sel_a_r;
    if (accept) begin
      stat_nxt  = ST_OK;
      rd_ok_nxt = 1'b0;
      sel_a_nxt = IW'(in_position);
      case (cmd)
        CMD_FRONT_IN: begin
          if (full) stat_nxt = ST_FULL;
          else begin
            op        = CELL_SHR;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_BACK_IN: begin
          if (full) stat_nxt = ST_FULL;
          else begin
            op        = CELL_FILL;
            hi        = count_r + 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_FRONT_OUT: begin
          if (empty) stat_nxt = ST_EMPTY;
          else begin
            op        = CELL_SHL;
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_BACK_OUT: begin
          if (empty) stat_nxt = ST_EMPTY;
          else count_nxt = count_r - 1'b1;
        end
        CMD_READ_AT: begin
          if (32'(in_position) >= 32'(count_r)) stat_nxt = ST_RANGE;
          else rd_ok_nxt = 1'b1;
        end
        CMD_RESIZE: begin
          if (32'(in_target_count) > 32'(CAPACITY)) stat_nxt = ST_BIG;
          else begin
            // growing fills [count, target); shrinking only drops the count
            op        = CELL_FILL;
            hi        = CW'(in_target_count);
            count_nxt = CW'(in_target_count);
          end
        end
        CMD_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end
    sel_b_nxt = accept ? IW'(count_nxt - 1'b1) : sel_b_r;
  end

  // cell row
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DW-1:0] left_s, right_s, sa_in, sb_in;
      if (gi == 0) begin : g_first
        assign left_s = wdata;
        assign sa_in  = '0;
        assign sb_in  = '0;
      end else begin : g_mid
        assign left_s = data_w[gi-1];
        assign sa_in  = scan_a_w[gi-1];
        assign sb_in  = scan_b_w[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_s = data_w[gi];
      end else begin : g_nlast
        assign right_s = data_w[gi+1];
      end
      cdq_cell #(
        .IDX      (gi),
        .DW       (DW),
        .CW       (CW),
        .IW       (IW),
        .REG_SCAN ((gi % CdqGroup == CdqGroup - 1) || (gi == CAPACITY - 1))
      ) u_cell (
        .clk       (clk),
        .op        (op),
        .lo        (lo),
        .hi        (hi),
        .wdata     (wdata),
        .left_in   (left_s),
        .right_in  (right_s),
        .data_o    (data_w[gi]),
        .sel_a     (sel_a_r),
        .sel_b     (sel_b_r),
        .scan_a_in (sa_in),
        .scan_b_in (sb_in),
        .scan_a_o  (scan_a_w[gi]),
        .scan_b_o  (scan_b_w[gi])
      );
    end
  endgenerate

  // sequencer: wait for the select chains to drain, then post the result
  always_comb begin
    state_nxt     = state_r;
    scnt_nxt      = scnt_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
          scnt_nxt  = '0;
        end
      end
      S_SCAN: begin
        scnt_nxt = scnt_r + 1'b1;
        if (scnt_r == SCW'(NSTG - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
      stat_r      <= ST_OK;
      rd_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
      stat_r      <= stat_nxt;
      rd_ok_r     <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_a_r <= sel_a_nxt;
    sel_b_r <= sel_b_nxt;
    if (load_out) begin
      o_read_r  <= rd_ok_r ? 32'(scan_a_w[CAPACITY-1]) : 32'd0;
      o_front_r <= empty ? 32'd0 : 32'(data_w[0]);
      o_back_r  <= empty ? 32'd0 : 32'(scan_b_w[CAPACITY-1]);
      o_occ_r   <= 9'(count_r);
      o_empty_r <= empty;
      o_stat_r  <= stat_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_word  = o_read_r;
  assign out_front_word = o_front_r;
  assign out_back_word  = o_back_r;
  assign out_occupancy  = o_occ_r;
  assign out_is_empty   = o_empty_r;
  assign out_status     = o_stat_r;

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == CMD_CLEAR) |=> (count_r == '0))
    else $error("clear left entries");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (state_r == S_DONE && scnt_r == SCW'(NSTG)))
    else $error("result posted before scan drained");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(count_r))
    else $error("queue changed while an item is in work");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import cdq_pkg::*;

  // A shadow deque predicts the result of every accepted command. Expected
  // results wait in a small ring; a separate process compares each result from
  // the block with the oldest one and prints the first ten mismatches in full.

  localparam int Cap      = CdqCapacity;
  localparam int ExpDepth = 16;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_cmd;
  logic [31:0] in_item_value;
  logic [7:0]  in_position;
  logic [8:0]  in_target_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_word;
  logic [31:0] out_front_word;
  logic [31:0] out_back_word;
  logic [8:0]  out_occupancy;
  logic        out_is_empty;
  logic [2:0]  out_status;

  circular_double_ended_queue_unit DUT (.*);

  typedef struct packed {
    logic [31:0] read_word;
    logic [31:0] front_word;
    logic [31:0] back_word;
    logic [8:0]  occupancy;
    logic        is_empty;
    logic [2:0]  status;
  } deque_result_t;

  // shadow deque state
  logic [31:0] shadow_slots [Cap];
  int unsigned shadow_head;
  int unsigned shadow_tail;
  int unsigned shadow_count;

  // expected results: written by the sender, read by the checker
  deque_result_t exp_slots [ExpDepth];
  int unsigned   exp_wr;
  int unsigned   exp_rd;
  int          mismatch_count;
  int          hold_off_cycles;  // long stall requested of the receiver
  bit          long_gaps_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned wrap_up(int unsigned p);
    return (p + 1 >= Cap) ? 0 : p + 1;
  endfunction

  function automatic int unsigned wrap_down(int unsigned p);
    return (p == 0) ? Cap - 1 : p - 1;
  endfunction

  function automatic int unsigned exp_level();
    return exp_wr - exp_rd;
  endfunction

  // Apply one command to the shadow deque and return what the block must report.
  function automatic deque_result_t apply_command(cmd_t cmd, logic [31:0] word,
                                                  logic [7:0] pos, logic [8:0] target);
    deque_result_t r;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_FRONT_IN: begin
        if (shadow_count >= Cap) r.status = ST_FULL;
        else begin
          shadow_head = wrap_down(shadow_head);
          shadow_slots[shadow_head] = word;
          shadow_count++;
        end
      end
      CMD_BACK_IN: begin
        if (shadow_count >= Cap) r.status = ST_FULL;
        else begin
          shadow_slots[shadow_tail] = word;
          shadow_tail = wrap_up(shadow_tail);
          shadow_count++;
        end
      end
      CMD_FRONT_OUT: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          shadow_head = wrap_up(shadow_head);
          shadow_count--;
        end
      end
      CMD_BACK_OUT: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          shadow_tail = wrap_down(shadow_tail);
          shadow_count--;
        end
      end
      CMD_READ_AT: begin
        if (pos >= shadow_count) r.status = ST_RANGE;
        else r.read_word = shadow_slots[(shadow_head + pos) % Cap];
      end
      CMD_RESIZE: begin
        if (target > Cap) r.status = ST_BIG;
        else begin
          while (shadow_count < target) begin
            shadow_slots[shadow_tail] = word;
            shadow_tail = wrap_up(shadow_tail);
            shadow_count++;
          end
          while (shadow_count > target) begin
            shadow_tail = wrap_down(shadow_tail);
            shadow_count--;
          end
        end
      end
      CMD_CLEAR: begin
        shadow_head = 0;
        shadow_tail = 0;
        shadow_count = 0;
      end
      default: ;
    endcase
    if (shadow_count != 0) begin
      r.front_word = shadow_slots[shadow_head];
      r.back_word  = shadow_slots[wrap_down(shadow_tail)];
    end
    r.occupancy = shadow_count[8:0];
    r.is_empty  = (shadow_count == 0);
    return r;
  endfunction

  // Sender gap: mostly none or short, sometimes long when long gaps are on.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return long_gaps_on ? $urandom_range(10, 60) : 0;
  endfunction

  // Offer one item and hold it until the block takes it. Valid drops only
  // when a gap follows, so back to back items never drive it twice at an edge.
  task automatic send_item(cmd_t cmd, logic [31:0] word, logic [7:0] pos,
                           logic [8:0] target);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_item_value   <= word;
    in_position     <= pos;
    in_target_count <= target;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: predict now
    exp_slots[exp_wr % ExpDepth] = apply_command(cmd, word, pos, target);
    exp_wr++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_level() != 0) @(posedge clk);
  endtask

  // Position that hits a held entry (when there is one).
  function automatic logic [7:0] held_position();
    if (shadow_count == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, shadow_count - 1));
  endfunction

  task automatic test_directed();
    send_item(CMD_FRONT_OUT, '0, '0, '0);            // pop on empty
    send_item(CMD_BACK_OUT, '0, '0, '0);
    send_item(CMD_READ_AT, '0, 8'd0, '0);            // read on empty
    send_item(CMD_BACK_IN, 32'hFFFF_FFFF, '0, '0);
    send_item(CMD_FRONT_IN, 32'h0000_0000, '0, '0);
    send_item(CMD_FRONT_IN, 32'hA5A5_5A5A, '0, '0);
    send_item(CMD_READ_AT, '0, 8'd2, '0);
    send_item(CMD_READ_AT, '0, 8'd3, '0);            // past the end
    send_item(CMD_READ_AT, '0, 8'hFF, '0);
    send_item(CMD_NOP, 32'h1234_5678, 8'h11, 9'h1FF); // unused code
    send_item(CMD_RESIZE, 32'hDEAD_BEEF, '0, 9'd257);  // too large
    send_item(CMD_RESIZE, 32'hDEAD_BEEF, '0, 9'h1FF);
    send_item(CMD_RESIZE, 32'h5555_AAAA, '0, 9'd256);  // fill to capacity
    send_item(CMD_BACK_IN, 32'h1, '0, '0);           // full
    send_item(CMD_FRONT_IN, 32'h2, '0, '0);          // full
    send_item(CMD_READ_AT, '0, 8'hFF, '0);           // last entry
    send_item(CMD_FRONT_OUT, '0, '0, '0);
    send_item(CMD_BACK_IN, 32'h8000_0001, '0, '0);   // refills to capacity
    send_item(CMD_RESIZE, '0, '0, 9'd3);             // shrink
    send_item(CMD_BACK_OUT, '0, '0, '0);
    send_item(CMD_RESIZE, '0, '0, 9'd0);
    send_item(CMD_CLEAR, '0, '0, '0);
    send_item(CMD_FRONT_IN, 32'h7FFF_FFFF, '0, '0);  // wraps head below 0
    send_item(CMD_CLEAR, '0, '0, '0);
  endtask

  // Random traffic biased toward valid operations, with occasional faults.
  task automatic test_random(int n);
    int roll;
    cmd_t cmd;
    logic [8:0] target;
    logic [7:0] pos;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      pos = held_position();
      target = 9'($urandom_range(0, 12));
      if (roll < 20) cmd = CMD_FRONT_IN;
      else if (roll < 42) cmd = CMD_BACK_IN;
      else if (roll < 52) cmd = CMD_FRONT_OUT;
      else if (roll < 62) cmd = CMD_BACK_OUT;
      else if (roll < 82) cmd = CMD_READ_AT;
      else if (roll < 92) cmd = CMD_RESIZE;
      else if (roll < 94) cmd = CMD_CLEAR;
      else begin
        cmd = cmd_t'($urandom_range(0, 7));
        pos = 8'($urandom_range(0, 255));
        target = 9'($urandom_range(0, 511));
      end
      if (cmd == CMD_RESIZE && $urandom_range(0, 9) == 0)
        target = 9'($urandom_range(200, 300));
      send_item(cmd, $urandom(), pos, target);
    end
  endtask

  // Receiver stalls while the sender keeps offering: block fills and stalls input.
  task automatic test_backpressure();
    hold_off_cycles = 400;
    test_random(20);
    wait_drained();
  endtask

  // Sender pauses until everything has drained, then resumes.
  task automatic test_drain_pause();
    test_random(30);
    wait_drained();
    test_random(30);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = $urandom_range(0, 99);
      if (stall < 65) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        if (stall > 95 && long_gaps_on) repeat ($urandom_range(10, 80)) @(posedge clk);
        else repeat ($urandom_range(0, 3)) @(posedge clk);
      end
    end
  end

  // Result checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_read_word, out_front_word, out_back_word, out_occupancy,
             out_is_empty, out_status};
      if (exp_level() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = exp_slots[exp_rd % ExpDepth];
        exp_rd++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: exp rd=%h fr=%h bk=%h occ=%0d emp=%b st=%0d",
                      " | got rd=%h fr=%h bk=%h occ=%0d emp=%b st=%0d"},
                     want.read_word, want.front_word, want.back_word, want.occupancy,
                     want.is_empty, want.status, got.read_word, got.front_word,
                     got.back_word, got.occupancy, got.is_empty, got.status);
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_NOP;
    in_item_value = '0;
    in_position = '0;
    in_target_count = '0;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_count = 0;
    exp_wr = 0;
    exp_rd = 0;
    mismatch_count = 0;
    hold_off_cycles = 0;
    long_gaps_on = 1'b0;
    for (int i = 0; i < Cap; i++) shadow_slots[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    long_gaps_on = 1'b1;
    test_random(900);
    long_gaps_on = 1'b0;
    test_drain_pause();
    long_gaps_on = 1'b1;
    test_random(1000);

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && exp_level() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Worst case: about 2000 items, each with a full scan, the longest stall and gap, plus hold-offs.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_cell.sv
hw/rtl/circular_double_ended_queue_unit.sv
test/tb_top.sv
